>>> hw/rtl/stt3_pkg.sv
// Types and constants shared by the 3D step-toward-target datapath.
`timescale 1ns / 1ps
package stt3_pkg;

  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned MAG_W     = 33;
  localparam int unsigned SQ_W      = 65;
  localparam int unsigned SUM_W     = 66;
  localparam int unsigned DIST_W    = 34;
  localparam int unsigned RATIO_W   = 33;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_THRESHOLD = 1'b1;

  localparam logic [CFG_W-1:0] STEP_LENGTH_RST      = 31'd131072;
  localparam logic [CFG_W-1:0] ARRIVE_THRESHOLD_RST = 31'd13107;

  typedef enum logic [1:0] {
    MODE_REACHED,
    MODE_TARGET,
    MODE_HOLD,
    MODE_MOVE
  } stt3_mode_e;

  typedef struct packed {
    logic [31:0] cur_x;
    logic [31:0] cur_y;
    logic [31:0] cur_z;
    logic [31:0] tgt_x;
    logic [31:0] tgt_y;
    logic [31:0] tgt_z;
  } stt3_in_t;

  typedef struct packed {
    logic [31:0] next_x;
    logic [31:0] next_y;
    logic [31:0] next_z;
    logic        reached;
  } stt3_out_t;

  // Per-item sideband carried alongside the root and divide pipelines
  typedef struct packed {
    logic [2:0][31:0]      cur;
    logic [2:0][31:0]      tgt;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
    stt3_mode_e            mode;
  } stt3_side_t;

endpackage

>>> hw/rtl/stt3_sq_lane.sv
// One axis lane: difference, magnitude and square of the magnitude.
`timescale 1ns / 1ps
module stt3_sq_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [31:0]                 cur_i,
  input  logic [31:0]                 tgt_i,
  output logic                        neg_o,
  output logic [stt3_pkg::MAG_W-1:0]  mag_o,
  output logic [stt3_pkg::SQ_W-1:0]   sq_o
);

  logic [32:0]                 diff;
  logic [stt3_pkg::MAG_W-1:0]  mag_a_d, mag_a_q, mag_b_q;
  logic                        neg_a_q, neg_b_q;
  logic [stt3_pkg::SQ_W-1:0]   sq_d, sq_q;
  logic [63:0]                 prod;

  assign diff    = {tgt_i[31], tgt_i} - {cur_i[31], cur_i};
  assign mag_a_d = diff[32] ? (33'd0 - diff) : diff;

  // A magnitude of exactly 2^32 has a zero low word, so its square is 2^64
  assign prod = {32'd0, mag_a_q[31:0]} * {32'd0, mag_a_q[31:0]};
  assign sq_d = mag_a_q[32] ? {1'b1, 64'd0} : {1'b0, prod};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q <= diff[32];
      mag_a_q <= mag_a_d;
      neg_b_q <= neg_a_q;
      mag_b_q <= mag_a_q;
      sq_q    <= sq_d;
    end
  end

  assign neg_o = neg_b_q;
  assign mag_o = mag_b_q;
  assign sq_o  = sq_q;

endmodule

>>> hw/rtl/stt3_isqrt.sv
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
module stt3_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [stt3_pkg::SUM_W-1:0]     rad_i,
  input  stt3_pkg::stt3_side_t           side_i,
  output logic                           valid_o,
  output logic [stt3_pkg::DIST_W-1:0]    root_o,
  output stt3_pkg::stt3_side_t           side_o
);

  localparam int unsigned NS = stt3_pkg::DIST_W;

  logic [stt3_pkg::SUM_W-1:0]  rem_q  [1:NS];
  logic [NS-1:0]               root_q [1:NS];
  stt3_pkg::stt3_side_t        side_q [1:NS];
  logic [NS:1]                 v_q;

  for (genvar gi = 0; gi < NS; gi++) begin : g_stage
    localparam int B = NS - 1 - gi;
    logic [stt3_pkg::SUM_W-1:0] rem_p;
    logic [NS-1:0]              root_p;
    stt3_pkg::stt3_side_t       side_p;
    logic                       v_p;
    logic [67:0]                trial, rem_w;
    logic                       take;

    if (gi == 0) begin : g_first
      assign rem_p  = rad_i;
      assign root_p = '0;
      assign side_p = side_i;
      assign v_p    = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[gi];
      assign root_p = root_q[gi];
      assign side_p = side_q[gi];
      assign v_p    = v_q[gi];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = ({34'd0, root_p} << (B + 1)) + (68'd1 << (2 * B));
    assign rem_w = {2'b00, rem_p};
    assign take  = rem_w >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[gi+1]  <= take ? stt3_pkg::SUM_W'(rem_w - trial) : rem_p;
        root_q[gi+1] <= take ? (root_p | (34'd1 << B)) : root_p;
        side_q[gi+1] <= side_p;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gi+1] <= 1'b0;
      end else if (en_i) begin
        v_q[gi+1] <= v_p;
      end
    end
  end

  assign valid_o = v_q[NS];
  assign root_o  = root_q[NS];
  assign side_o  = side_q[NS];

endmodule

>>> hw/rtl/stt3_div.sv
// Pipelined restoring divider for step * 2^32 / distance, one quotient bit per stage.
`timescale 1ns / 1ps
module stt3_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [stt3_pkg::CFG_W-1:0]     step_i,
  input  logic [stt3_pkg::DIST_W-1:0]    den_i,
  input  stt3_pkg::stt3_side_t           side_i,
  output logic                           valid_o,
  output logic [stt3_pkg::RATIO_W-1:0]   quot_o,
  output stt3_pkg::stt3_side_t           side_o
);

  localparam int unsigned NS    = stt3_pkg::RATIO_W;
  localparam int unsigned NUM_W = stt3_pkg::CFG_W + 32;

  logic [NUM_W-1:0]                 rem_q  [1:NS];
  logic [stt3_pkg::DIST_W-1:0]      den_q  [1:NS];
  logic [NS-1:0]                    quot_q [1:NS];
  stt3_pkg::stt3_side_t             side_q [1:NS];
  logic [NS:1]                      v_q;

  for (genvar gi = 0; gi < NS; gi++) begin : g_stage
    localparam int K = NS - 1 - gi;
    logic [NUM_W-1:0]             rem_p;
    logic [stt3_pkg::DIST_W-1:0]  den_p;
    logic [NS-1:0]                quot_p;
    stt3_pkg::stt3_side_t         side_p;
    logic                         v_p;
    logic [65:0]                  trial, rem_w;
    logic                         take;

    if (gi == 0) begin : g_first
      assign rem_p  = {step_i, 32'd0};
      assign den_p  = den_i;
      assign quot_p = '0;
      assign side_p = side_i;
      assign v_p    = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[gi];
      assign den_p  = den_q[gi];
      assign quot_p = quot_q[gi];
      assign side_p = side_q[gi];
      assign v_p    = v_q[gi];
    end

    assign trial = {32'd0, den_p} << K;
    assign rem_w = {3'b000, rem_p};
    assign take  = rem_w >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[gi+1]  <= take ? NUM_W'(rem_w - trial) : rem_p;
        den_q[gi+1]  <= den_p;
        quot_q[gi+1] <= take ? (quot_p | (33'd1 << K)) : quot_p;
        side_q[gi+1] <= side_p;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gi+1] <= 1'b0;
      end else if (en_i) begin
        v_q[gi+1] <= v_p;
      end
    end
  end

  assign valid_o = v_q[NS];
  assign quot_o  = quot_q[NS];
  assign side_o  = side_q[NS];

endmodule

>>> hw/rtl/stt3_mv_lane.sv
// One axis lane: scale the magnitude by the ratio and apply the move.
`timescale 1ns / 1ps
module stt3_mv_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [stt3_pkg::MAG_W-1:0]    mag_i,
  input  logic [stt3_pkg::RATIO_W-1:0]  ratio_i,
  input  logic [31:0]                   cur_i,
  input  logic                          neg_i,
  output logic [31:0]                   next_o
);

  logic [63:0] prod;
  logic [32:0] mv_d, mv_q;

  // Either operand at 2^32 has a zero low word, so the product is the other one
  assign prod = {32'd0, mag_i[31:0]} * {32'd0, ratio_i[31:0]};
  assign mv_d = mag_i[32]   ? ratio_i :
                ratio_i[32] ? mag_i   : {1'b0, prod[63:32]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mv_q <= mv_d;
    end
  end

  assign next_o = neg_i ? (cur_i - mv_q[31:0]) : (cur_i + mv_q[31:0]);

endmodule

>>> hw/rtl/step_toward_target_3d_top.sv
// Throughput: one item per cycle while the output is not stalled.
// 34 root stages and 33 divide stages, one bit each.
// A stalled output freezes the whole pipeline; input is taken whenever it advances.
// Reset clears all valid bits and loads step 2.0 m and arrival threshold 0.2 m.
`timescale 1ns / 1ps
module step_toward_target_3d_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  stt3_pkg::stt3_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output stt3_pkg::stt3_out_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [stt3_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [stt3_pkg::CFG_W-1:0]        cfg_data_i
);

  logic en;
  logic [stt3_pkg::CFG_W-1:0] step_q, thr_q;

  logic [2:0][31:0] cur_in, tgt_in, cur1_q, tgt1_q, cur2_q, tgt2_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;

  logic [2:0]                         neg2;
  logic [2:0][stt3_pkg::MAG_W-1:0]    mag2;
  logic [2:0][stt3_pkg::SQ_W-1:0]     sq2;
  logic [stt3_pkg::SUM_W-1:0]         sum3_d, sum3_q;
  stt3_pkg::stt3_side_t               side3_d, side3_q, side_r, side4_d, side4_q;
  stt3_pkg::stt3_side_t               side_v, side5_q;
  logic                               v_r, v_v;
  logic [stt3_pkg::DIST_W-1:0]        dist_r, dist4_q;
  logic [stt3_pkg::RATIO_W-1:0]       ratio_v;
  logic [2:0][31:0]                   next5;
  stt3_pkg::stt3_out_t                out_d, out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= stt3_pkg::STEP_LENGTH_RST;
      thr_q  <= stt3_pkg::ARRIVE_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stt3_pkg::REG_STEP_LENGTH:      step_q <= cfg_data_i;
        stt3_pkg::REG_ARRIVE_THRESHOLD: thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cur_in = {in_data_i.cur_z, in_data_i.cur_y, in_data_i.cur_x};
  assign tgt_in = {in_data_i.tgt_z, in_data_i.tgt_y, in_data_i.tgt_x};

  for (genvar gi = 0; gi < 3; gi++) begin : g_sq
    stt3_sq_lane u_sq (
      .clk_i (clk_i),
      .en_i  (en),
      .cur_i (cur_in[gi]),
      .tgt_i (tgt_in[gi]),
      .neg_o (neg2[gi]),
      .mag_o (mag2[gi]),
      .sq_o  (sq2[gi])
    );
  end

  always_comb begin
    sum3_d       = {1'b0, sq2[0]} + {1'b0, sq2[1]} + {1'b0, sq2[2]};
    side3_d.cur  = cur2_q;
    side3_d.tgt  = tgt2_q;
    side3_d.neg  = neg2;
    side3_d.mag  = mag2;
    side3_d.mode = stt3_pkg::MODE_HOLD;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cur1_q  <= cur_in;
      tgt1_q  <= tgt_in;
      cur2_q  <= cur1_q;
      tgt2_q  <= tgt1_q;
      sum3_q  <= sum3_d;
      side3_q <= side3_d;
      dist4_q <= dist_r;
      side4_q <= side4_d;
      side5_q <= side_v;
      out_q   <= out_d;
    end
  end

  stt3_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (sum3_q),
    .side_i  (side3_q),
    .valid_o (v_r),
    .root_o  (dist_r),
    .side_o  (side_r)
  );

  // Classify the item once the distance is known
  always_comb begin
    side4_d = side_r;
    if (dist_r < {3'd0, thr_q}) begin
      side4_d.mode = stt3_pkg::MODE_REACHED;
    end else if (dist_r < {3'd0, step_q}) begin
      side4_d.mode = stt3_pkg::MODE_TARGET;
    end else if (step_q == '0 || dist_r == '0) begin
      side4_d.mode = stt3_pkg::MODE_HOLD;
    end else begin
      side4_d.mode = stt3_pkg::MODE_MOVE;
    end
  end

  stt3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .step_i  (step_q),
    .den_i   (dist4_q),
    .side_i  (side4_q),
    .valid_o (v_v),
    .quot_o  (ratio_v),
    .side_o  (side_v)
  );

  for (genvar gi = 0; gi < 3; gi++) begin : g_mv
    stt3_mv_lane u_mv (
      .clk_i   (clk_i),
      .en_i    (en),
      .mag_i   (side_v.mag[gi]),
      .ratio_i (ratio_v),
      .cur_i   (side5_q.cur[gi]),
      .neg_i   (side5_q.neg[gi]),
      .next_o  (next5[gi])
    );
  end

  always_comb begin
    out_d.reached = 1'b0;
    out_d.next_x  = side5_q.tgt[0];
    out_d.next_y  = side5_q.tgt[1];
    out_d.next_z  = side5_q.tgt[2];
    case (side5_q.mode)
      stt3_pkg::MODE_REACHED: out_d.reached = 1'b1;
      stt3_pkg::MODE_TARGET:  ;
      stt3_pkg::MODE_HOLD: begin
        out_d.next_x = side5_q.cur[0];
        out_d.next_y = side5_q.cur[1];
        out_d.next_z = side5_q.cur[2];
      end
      stt3_pkg::MODE_MOVE: begin
        out_d.next_x = next5[0];
        out_d.next_y = next5[1];
        out_d.next_z = next5[2];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v_r;
      v5_q        <= v_v;
      out_valid_q <= v5_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sum of three squares stays below 3 * 2^64
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> sum3_q[65:64] != 2'b11)
    else $error("square sum out of range");

  // Root of a value below 2^66 fits in 33 bits
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_r |-> !dist_r[33])
    else $error("distance out of range");

  a_move_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && side4_q.mode == stt3_pkg::MODE_MOVE) |->
      (dist4_q != '0 && dist4_q >= {3'd0, step_q}))
    else $error("move chosen with distance below step");

  // Ratio never exceeds 2^32
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_v && side_v.mode == stt3_pkg::MODE_MOVE && ratio_v[32]) |-> ratio_v[31:0] == '0)
    else $error("ratio above one");

endmodule

>>> tb/step_toward_target_3d_top_tb.sv
// Self-checking testbench for the 3D step-toward-target datapath.
`timescale 1ns / 1ps
module step_toward_target_3d_top_tb;

  class setpoint_board;
    stt3_pkg::stt3_out_t pending_q[$];
    logic [30:0] step_len;
    logic [30:0] arrive_thr;
    int unsigned errors;

    function new();
      step_len   = stt3_pkg::STEP_LENGTH_RST;
      arrive_thr = stt3_pkg::ARRIVE_THRESHOLD_RST;
      errors     = 0;
    endfunction

    // Floor square root of a 66-bit sum, result below 2^34
    function logic [33:0] floor_root(logic [65:0] n);
      logic [33:0]  r;
      logic [33:0]  c;
      logic [67:0]  sq;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        c = r | (34'd1 << b);
        sq = c * c;
        if (sq <= {2'b00, n}) r = c;
      end
      return r;
    endfunction

    function void note_item(stt3_pkg::stt3_in_t it);
      logic signed [32:0] d [3];
      logic signed [31:0] cur [3];
      logic signed [31:0] tgt [3];
      logic [32:0]  mag [3];
      logic [65:0]  sum;
      logic [33:0]  root_dist;
      logic [63:0]  ratio;
      logic [95:0]  prod;
      logic [31:0]  mv;
      stt3_pkg::stt3_out_t r;
      cur[0] = it.cur_x; cur[1] = it.cur_y; cur[2] = it.cur_z;
      tgt[0] = it.tgt_x; tgt[1] = it.tgt_y; tgt[2] = it.tgt_z;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        d[i]   = 33'(tgt[i]) - 33'(cur[i]);
        mag[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
        sum    = sum + 66'(mag[i]) * 66'(mag[i]);
      end
      root_dist = floor_root(sum);
      r.reached = 1'b0;
      if (root_dist < 34'(arrive_thr)) begin
        r.reached = 1'b1;
        r.next_x = tgt[0]; r.next_y = tgt[1]; r.next_z = tgt[2];
      end else if (root_dist < 34'(step_len)) begin
        r.next_x = tgt[0]; r.next_y = tgt[1]; r.next_z = tgt[2];
      end else if (step_len == 0 || root_dist == 0) begin
        r.next_x = cur[0]; r.next_y = cur[1]; r.next_z = cur[2];
      end else begin
        ratio = ({33'd0, step_len} << 32) / 64'(root_dist);
        for (int i = 0; i < 3; i++) begin
          prod = 96'(mag[i]) * 96'(ratio);
          mv = prod[63:32];
          cur[i] = d[i][32] ? cur[i] - mv : cur[i] + mv;
        end
        r.next_x = cur[0]; r.next_y = cur[1]; r.next_z = cur[2];
      end
      pending_q = {pending_q, r};
    endfunction

    function void check_result(stt3_pkg::stt3_out_t got);
      stt3_pkg::stt3_out_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.next_x !== exp_r.next_x) begin
        $error("next_x expected %h actual %h", exp_r.next_x, got.next_x); errors++;
      end
      if (got.next_y !== exp_r.next_y) begin
        $error("next_y expected %h actual %h", exp_r.next_y, got.next_y); errors++;
      end
      if (got.next_z !== exp_r.next_z) begin
        $error("next_z expected %h actual %h", exp_r.next_z, got.next_z); errors++;
      end
      if (got.reached !== exp_r.reached) begin
        $error("reached expected %b actual %b", exp_r.reached, got.reached); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  stt3_pkg::stt3_in_t  in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  stt3_pkg::stt3_out_t out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [stt3_pkg::CFG_IDX_W-1:0] cfg_idx_i = stt3_pkg::REG_STEP_LENGTH;
  logic [stt3_pkg::CFG_W-1:0]     cfg_data_i = '0;

  setpoint_board board = new();
  bit  calm_phase = 1'b0;
  bit  hold_sink  = 1'b0;
  int  sink_stall = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  step_toward_target_3d_top uut (.*);

  // Receiver: random ready bursts, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
    if (hold_sink) begin
      out_ready_i <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall  <= sink_stall - 1;
      out_ready_i <= 1'b0;
    end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
      sink_stall  <= $urandom_range(1, 10) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_item(stt3_pkg::stt3_in_t it);
    int gap;
    if (!calm_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(it);
  endtask

  // Drop valid at the last transfer edge, then wait for every result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [stt3_pkg::CFG_IDX_W-1:0] idx,
                           logic [stt3_pkg::CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    if (idx == stt3_pkg::REG_STEP_LENGTH) board.step_len = val;
    else board.arrive_thr = val;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 8) - 4;
      3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  // Target mostly near the current point so short distances and arrivals show up
  function automatic stt3_pkg::stt3_in_t random_item();
    stt3_pkg::stt3_in_t it;
    int span;
    it.cur_x = pick_coord(); it.cur_y = pick_coord(); it.cur_z = pick_coord();
    if ($urandom_range(0, 2) == 0) begin
      it.tgt_x = pick_coord(); it.tgt_y = pick_coord(); it.tgt_z = pick_coord();
    end else begin
      span = 1 << $urandom_range(0, 20);
      it.tgt_x = it.cur_x + $urandom_range(0, 2 * span) - span;
      it.tgt_y = it.cur_y + $urandom_range(0, 2 * span) - span;
      it.tgt_z = it.cur_z + $urandom_range(0, 2 * span) - span;
    end
    return it;
  endfunction

  function automatic stt3_pkg::stt3_in_t make_item(logic [31:0] cx, cy, cz, tx, ty, tz);
    stt3_pkg::stt3_in_t it;
    it.cur_x = cx; it.cur_y = cy; it.cur_z = cz;
    it.tgt_x = tx; it.tgt_y = ty; it.tgt_z = tz;
    return it;
  endfunction

  initial begin
    logic [stt3_pkg::CFG_W-1:0] steps [5];
    logic [stt3_pkg::CFG_W-1:0] thrs  [5];
    steps = '{stt3_pkg::STEP_LENGTH_RST, 31'd0, 31'h7fff_ffff, 31'd65536, 31'd1};
    thrs  = '{stt3_pkg::ARRIVE_THRESHOLD_RST, 31'd0, 31'd13107, 31'h7fff_ffff,
              31'd300000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, arrival, short hop, full step, zero distance
    send_item(make_item(0, 0, 0, 0, 0, 0));
    send_item(make_item(0, 0, 0, 32'd1000, 0, 0));
    send_item(make_item(0, 0, 0, 32'h0001_0000, 0, 0));
    send_item(make_item(0, 0, 0, 32'h0010_0000, 32'hfff0_0000, 32'h0003_0000));
    send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_item(make_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(make_item(32'hffff_ffff, 32'h7fff_ffff, 0, 32'hffff_ffff, 32'h8000_0000, 0));
    send_item(make_item(32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
                        32'h1234_5678, 32'h1234_5678, 32'h1234_5678));
    send_item(make_item(0, 0, 0, 0, 0, 32'd13107));
    send_item(make_item(0, 0, 0, 0, 0, 32'd13106));
    send_item(make_item(0, 0, 0, 0, 32'h0002_0000, 0));
    send_item(make_item(0, 0, 0, 0, 32'h0001_ffff, 0));
    drain();

    // Zero step and zero threshold: hold path
    write_reg(stt3_pkg::REG_STEP_LENGTH, 31'd0);
    write_reg(stt3_pkg::REG_ARRIVE_THRESHOLD, 31'd0);
    send_item(make_item(0, 0, 0, 0, 0, 0));
    send_item(make_item(5, 6, 7, 5, 6, 7));
    send_item(make_item(0, 0, 0, 32'h0005_0000, 32'h0001_0000, 32'hffff_0000));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(stt3_pkg::REG_STEP_LENGTH, steps[ph]);
      write_reg(stt3_pkg::REG_ARRIVE_THRESHOLD, thrs[ph]);
      if (ph == 4) calm_phase = 1'b1;
      for (int n = 0; n < 220; n++) begin
        if (ph == 1 && n == 50) begin
          fork
            begin
              hold_sink = 1'b1;
              repeat (200) @(posedge clk_i);
              hold_sink = 1'b0;
            end
          join_none
        end
        if (ph == 2 && n == 100) begin
          in_valid_i <= 1'b0;
          while (board.pending_q.size() != 0) @(posedge clk_i);
        end
        send_item(random_item());
      end
      drain();
    end

    if (board.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

>>> step_toward_target_3d_top.f
hw/rtl/stt3_pkg.sv
hw/rtl/stt3_sq_lane.sv
hw/rtl/stt3_isqrt.sv
hw/rtl/stt3_div.sv
hw/rtl/stt3_mv_lane.sv
hw/rtl/step_toward_target_3d_top.sv
tb/step_toward_target_3d_top_tb.sv
